>>> design/decimal_display_formatter_assert.svh
// Assertion macros used by the top level of the decimal display formatter RTL.
`ifndef DECIMAL_DISPLAY_FORMATTER_ASSERT_SVH
`define DECIMAL_DISPLAY_FORMATTER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define DDF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define DDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ddf_pkg.sv
// Shared constants, widths and types of the decimal display formatter.
`default_nettype none
package ddf_pkg;

   localparam int unsigned VALUE_W  = 17;
   localparam int unsigned COLUMN_W = 4;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned DIGIT_W  = 4;

   localparam logic [VALUE_W-1:0] MAX_VALUE = 17'd99999;

   localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] ASCII_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] ROW0_CMD    = 8'h80;
   localparam logic [BYTE_W-1:0] ROW1_CMD    = 8'hC0;

   localparam int unsigned WEIGHT_TEN_THOUSANDS = 10000;
   localparam int unsigned WEIGHT_THOUSANDS     = 1000;
   localparam int unsigned WEIGHT_HUNDREDS      = 100;
   localparam int unsigned WEIGHT_TENS          = 10;

   // Bytes per request: one command byte, then five characters.
   localparam int unsigned NUM_BYTES = 6;
   localparam int unsigned IDX_W     = $clog2(NUM_BYTES);
   localparam logic [IDX_W-1:0] IDX_CMD  = IDX_W'(0);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BYTES - 1);

   // Digits above units, shifted in as each stage resolves one;
   // digits[3] ends as ten-thousands, digits[0] as tens.
   typedef struct packed {
      logic [BYTE_W-1:0]             cmd;
      logic [3:0][DIGIT_W-1:0]       digits;
   } meta_type;

endpackage
`default_nettype wire

>>> design/ddf_req_if.sv
// Request channel: number, display row and starting column.
`default_nettype none
interface ddf_req_if;
   logic                             valid;
   logic                             ready;
   logic [ddf_pkg::VALUE_W-1:0]      value;
   logic                             line_sel;
   logic [ddf_pkg::COLUMN_W-1:0]     column;

   modport source (output valid, value, line_sel, column, input ready);
   modport sink   (input valid, value, line_sel, column, output ready);
endinterface
`default_nettype wire

>>> design/ddf_rsp_if.sv
// Response channel: one display byte per transfer.
`default_nettype none
interface ddf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ddf_pkg::BYTE_W-1:0]       out_byte;
   logic                             is_char;
   logic                             last;

   modport source (output valid, out_byte, is_char, last, input ready);
   modport sink   (input valid, out_byte, is_char, last, output ready);
endinterface
`default_nettype wire

>>> design/decimal_display_formatter.sv
// Top level of the decimal display formatter: saturation, digit pipeline, serializer.
`default_nettype none
// Each request carries a number, a display row and a starting column; the
// block answers with six bytes: a set-address command (0x80 | column for the
// top row, 0xC0 | column for the bottom row), then five ASCII characters from
// ten-thousands down to units. Leading zeros show as spaces, the units digit
// always shows, and numbers above 99999 show as 99999. A request passes five
// register stages (saturate, then one stage per digit from ten-thousands to
// tens) before the serializer loads it and offers its command byte. The
// pipeline takes a new request every cycle while it has room; the sustained
// rate is set by the response channel, which carries one byte per transfer
// and six bytes per request. The serializer holds one formatted request and
// takes the next one in the cycle its units byte leaves, so back-to-back
// requests stream without gaps.
module decimal_display_formatter (
   input  wire logic    clock,
   input  wire logic    reset,
   ddf_req_if.sink      req_chan,
   ddf_rsp_if.source    rsp_chan
);

   `include "decimal_display_formatter_assert.svh"

   localparam int unsigned REM_A_W = $clog2(10 * ddf_pkg::WEIGHT_TEN_THOUSANDS);
   localparam int unsigned REM_B_W = $clog2(ddf_pkg::WEIGHT_TEN_THOUSANDS);
   localparam int unsigned REM_C_W = $clog2(ddf_pkg::WEIGHT_THOUSANDS);
   localparam int unsigned REM_D_W = $clog2(ddf_pkg::WEIGHT_HUNDREDS);
   localparam int unsigned REM_E_W = $clog2(ddf_pkg::WEIGHT_TENS);

   // Stage A: saturated number and address command.
   logic                                vld_a_ff;
   logic [REM_A_W-1:0]                  rem_a_ff;
   logic [REM_A_W-1:0]                  rem_a_in;
   ddf_pkg::meta_type                   meta_a_ff;
   ddf_pkg::meta_type                   meta_a_in;

   logic                                vld_b, vld_c, vld_d, vld_e;
   logic [REM_B_W-1:0]                  rem_b;
   logic [REM_C_W-1:0]                  rem_c;
   logic [REM_D_W-1:0]                  rem_d;
   logic [REM_E_W-1:0]                  rem_e;
   ddf_pkg::meta_type                   meta_b, meta_c, meta_d, meta_e;

   logic                                ser_ready;
   logic                                adv_a, adv_b, adv_c, adv_d, adv_e;

   // A stage advances when it is empty or the stage after it advances;
   // a full stage in front of a stalled one holds its request.
   assign adv_e = !vld_e || ser_ready;
   assign adv_d = !vld_d || adv_e;
   assign adv_c = !vld_c || adv_d;
   assign adv_b = !vld_b || adv_c;
   assign adv_a = !vld_a_ff || adv_b;

   assign req_chan.ready = adv_a;

   // Clamp out-of-range numbers and build the set-address command.
   always_comb begin
      if (req_chan.value > ddf_pkg::MAX_VALUE) begin
         rem_a_in = REM_A_W'(ddf_pkg::MAX_VALUE);
      end else begin
         rem_a_in = REM_A_W'(req_chan.value);
      end
      meta_a_in.cmd    = (req_chan.line_sel ? ddf_pkg::ROW1_CMD : ddf_pkg::ROW0_CMD)
                         | {4'b0, req_chan.column};
      meta_a_in.digits = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (adv_a) begin
         vld_a_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a && req_chan.valid) begin
         rem_a_ff  <= rem_a_in;
         meta_a_ff <= meta_a_in;
      end
   end

   // Stage B: ten-thousands digit.
   ddf_digit_stage #(.WEIGHT(ddf_pkg::WEIGHT_TEN_THOUSANDS)) u_stage_b (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv_b),
      .src_valid (vld_a_ff),
      .src_rem   (rem_a_ff),
      .src_meta  (meta_a_ff),
      .dst_valid (vld_b),
      .dst_rem   (rem_b),
      .dst_meta  (meta_b)
   );

   // Stage C: thousands digit.
   ddf_digit_stage #(.WEIGHT(ddf_pkg::WEIGHT_THOUSANDS)) u_stage_c (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv_c),
      .src_valid (vld_b),
      .src_rem   (rem_b),
      .src_meta  (meta_b),
      .dst_valid (vld_c),
      .dst_rem   (rem_c),
      .dst_meta  (meta_c)
   );

   // Stage D: hundreds digit.
   ddf_digit_stage #(.WEIGHT(ddf_pkg::WEIGHT_HUNDREDS)) u_stage_d (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv_d),
      .src_valid (vld_c),
      .src_rem   (rem_c),
      .src_meta  (meta_c),
      .dst_valid (vld_d),
      .dst_rem   (rem_d),
      .dst_meta  (meta_d)
   );

   // Stage E: tens digit; the remainder left is the units digit.
   ddf_digit_stage #(.WEIGHT(ddf_pkg::WEIGHT_TENS)) u_stage_e (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv_e),
      .src_valid (vld_d),
      .src_rem   (rem_d),
      .src_meta  (meta_d),
      .dst_valid (vld_e),
      .dst_rem   (rem_e),
      .dst_meta  (meta_e)
   );

   // Format the characters and send six bytes per request.
   ddf_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .src_valid (vld_e),
      .src_meta  (meta_e),
      .src_units (rem_e),
      .src_ready (ser_ready),
      .rsp       (rsp_chan)
   );

   // A command byte is always followed at once by a character.
   `DDF_ASSERT_NEXT(a_cmd_then_char, clock, reset,
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.is_char,
      rsp_chan.valid && rsp_chan.is_char, "command byte not followed by a character")
   // No bubble inside a request's six bytes.
   `DDF_ASSERT_NEXT(a_no_gap, clock, reset,
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last,
      rsp_chan.valid, "gap inside a request's bytes")
   // The units byte is always a digit, never a blank.
   `DDF_ASSERT_SAME(a_units_digit, clock, reset,
      rsp_chan.valid && rsp_chan.last,
      rsp_chan.is_char && rsp_chan.out_byte[7:4] == 4'h3, "units byte is not a digit")
   // A stalled tens stage holds its request.
   `DDF_ASSERT_NEXT(a_stall_holds, clock, reset,
      vld_e && !ser_ready,
      vld_e && $stable(rem_e) && $stable(meta_e), "stalled stage lost its request")

endmodule
`default_nettype wire

>>> design/ddf_digit_stage.sv
// One pipeline stage that resolves a single decimal digit of the number.
`default_nettype none
module ddf_digit_stage #(
   parameter int unsigned WEIGHT = ddf_pkg::WEIGHT_TENS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          src_valid,
   input  wire logic [$clog2(10*WEIGHT)-1:0]  src_rem,
   input  wire ddf_pkg::meta_type             src_meta,
   output      logic                          dst_valid,
   output      logic [$clog2(WEIGHT)-1:0]     dst_rem,
   output      ddf_pkg::meta_type             dst_meta
);

   localparam int unsigned IN_W  = $clog2(10*WEIGHT);
   localparam int unsigned OUT_W = $clog2(WEIGHT);

   logic                           vld_ff;
   logic [OUT_W-1:0]               rem_ff;
   ddf_pkg::meta_type              meta_ff;
   logic [OUT_W-1:0]               rem_in;
   ddf_pkg::meta_type              meta_in;
   logic [ddf_pkg::DIGIT_W-1:0]    digit;
   logic [IN_W-1:0]                sub;
   logic [IN_W-1:0]                diff;

   // Compare against one to nine times the weight; the highest match wins.
   always_comb begin
      digit = '0;
      sub   = '0;
      for (int k = 1; k <= 9; k++) begin
         if (src_rem >= IN_W'(k * WEIGHT)) begin
            digit = ddf_pkg::DIGIT_W'(k);
            sub   = IN_W'(k * WEIGHT);
         end
      end
      diff           = src_rem - sub;
      rem_in         = diff[OUT_W-1:0];
      meta_in        = src_meta;
      meta_in.digits = {src_meta.digits[2:0], digit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && src_valid) begin
         rem_ff  <= rem_in;
         meta_ff <= meta_in;
      end
   end

   assign dst_valid = vld_ff;
   assign dst_rem   = rem_ff;
   assign dst_meta  = meta_ff;

endmodule
`default_nettype wire

>>> design/ddf_serializer.sv
// Builds the six display bytes of a request and sends them one per transfer.
`default_nettype none
module ddf_serializer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              src_valid,
   input  wire ddf_pkg::meta_type                 src_meta,
   input  wire logic [ddf_pkg::DIGIT_W-1:0]       src_units,
   output      logic                              src_ready,
   ddf_rsp_if.source                              rsp
);

   logic                                   busy_ff;
   logic                                   busy_in;
   logic [ddf_pkg::IDX_W-1:0]              idx_ff;
   logic [ddf_pkg::IDX_W-1:0]              idx_in;
   logic [ddf_pkg::BYTE_W-1:0]             bytes_ff [ddf_pkg::NUM_BYTES];
   logic [ddf_pkg::BYTE_W-1:0]             bytes_in [ddf_pkg::NUM_BYTES];
   logic [ddf_pkg::DIGIT_W-1:0]            dig [ddf_pkg::NUM_BYTES];
   logic                                   shown;
   logic                                   sent;
   logic                                   load;

   assign sent      = busy_ff && rsp.ready;
   assign src_ready = !busy_ff || (rsp.ready && (idx_ff == ddf_pkg::IDX_LAST));
   assign load      = src_valid && src_ready;

   // Format the characters; leading zeros blank until the first nonzero
   // digit, and the units digit always shows.
   always_comb begin
      dig[0] = '0;
      dig[1] = src_meta.digits[3];
      dig[2] = src_meta.digits[2];
      dig[3] = src_meta.digits[1];
      dig[4] = src_meta.digits[0];
      dig[5] = src_units;
      bytes_in[0] = src_meta.cmd;
      shown = 1'b0;
      for (int j = 1; j < ddf_pkg::NUM_BYTES; j++) begin
         if (dig[j] != '0 || j == ddf_pkg::NUM_BYTES - 1) begin
            shown = 1'b1;
         end
         bytes_in[j] = shown ? (ddf_pkg::ASCII_ZERO | {4'b0, dig[j]}) : ddf_pkg::ASCII_SPACE;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = ddf_pkg::IDX_CMD;
      end else if (sent) begin
         if (idx_ff == ddf_pkg::IDX_LAST) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= ddf_pkg::IDX_CMD;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= bytes_in;
      end
   end

   assign rsp.valid    = busy_ff;
   assign rsp.out_byte = bytes_ff[idx_ff];
   assign rsp.is_char  = (idx_ff != ddf_pkg::IDX_CMD);
   assign rsp.last     = (idx_ff == ddf_pkg::IDX_LAST);

endmodule
`default_nettype wire

>>> verif/display_byte_checker.sv
// Watches both channels, predicts the six display bytes of each request and compares them.
`timescale 1ns / 1ps
module display_byte_checker (
   input  logic clock,
   input  logic reset,
   ddf_req_if   req_mon,
   ddf_rsp_if   rsp_mon,
   output int   pending_bytes,
   output int   mismatch_count
);

   typedef struct packed {
      logic [ddf_pkg::BYTE_W-1:0] out_byte;
      logic                       is_char;
      logic                       last;
   } display_byte_type;

   display_byte_type expected_bytes[$];

   initial begin
      pending_bytes  = 0;
      mismatch_count = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
   endtask

   // Push the command byte and the five digit characters that one request yields.
   function automatic void queue_display_bytes(input logic [ddf_pkg::VALUE_W-1:0] value,
                                               input logic line_sel,
                                               input logic [ddf_pkg::COLUMN_W-1:0] column);
      int unsigned      weights[5];
      int unsigned      rest;
      int unsigned      digit;
      bit               shown;
      display_byte_type entry;
      weights = '{ddf_pkg::WEIGHT_TEN_THOUSANDS, ddf_pkg::WEIGHT_THOUSANDS,
                  ddf_pkg::WEIGHT_HUNDREDS, ddf_pkg::WEIGHT_TENS, 1};
      rest    = (value > ddf_pkg::MAX_VALUE) ? ddf_pkg::MAX_VALUE : value;
      shown   = 1'b0;
      entry.out_byte = (line_sel ? ddf_pkg::ROW1_CMD : ddf_pkg::ROW0_CMD)
                       | {{(ddf_pkg::BYTE_W-ddf_pkg::COLUMN_W){1'b0}}, column};
      entry.is_char  = 1'b0;
      entry.last     = 1'b0;
      expected_bytes.push_back(entry);
      for (int i = 0; i < 5; i++) begin
         digit = rest / weights[i];
         rest  = rest - digit * weights[i];
         if (digit != 0 || i == 4) shown = 1'b1;
         entry.out_byte = shown ? ddf_pkg::ASCII_ZERO + ddf_pkg::BYTE_W'(digit)
                                : ddf_pkg::ASCII_SPACE;
         entry.is_char  = 1'b1;
         entry.last     = (i == 4);
         expected_bytes.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      display_byte_type want;
      if (reset) begin
         expected_bytes.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            queue_display_bytes(req_mon.value, req_mon.line_sel, req_mon.column);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected byte", rsp_mon.out_byte, 0);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_mon.out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_mon.out_byte, want.out_byte);
               if (rsp_mon.is_char !== want.is_char)
                  report_mismatch("is_char", rsp_mon.is_char, want.is_char);
               if (rsp_mon.last !== want.last)
                  report_mismatch("last", rsp_mon.last, want.last);
            end
         end
      end
      pending_bytes <= expected_bytes.size();
   end
endmodule

>>> verif/tb.sv
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps
module tb;

   logic clock;
   logic reset;
   bit   idle_enable;
   int   pending_bytes;
   int   mismatch_count;
   int   stall_left;

   ddf_req_if req_chan ();
   ddf_rsp_if rsp_chan ();

   decimal_display_formatter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predict and compare beside the block; only the counts come back here.
   display_byte_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .pending_bytes  (pending_bytes),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Drive every input to a known value before the first edge.
   initial begin
      reset             = 1'b1;
      idle_enable       = 1'b0;
      stall_left        = 0;
      req_chan.valid    = 1'b0;
      req_chan.value    = '0;
      req_chan.line_sel = 1'b0;
      req_chan.column   = '0;
      rsp_chan.ready    = 1'b0;
   end

   // Idle length: mostly zero or short, now and then long.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Random number spread over every digit count, with some above the saturation point.
   function automatic logic [ddf_pkg::VALUE_W-1:0] random_value();
      unique case ($urandom_range(0, 9))
         0:       return ddf_pkg::VALUE_W'($urandom_range(0, 131071));
         1:       return ddf_pkg::VALUE_W'($urandom_range(100000, 131071));
         2:       return ddf_pkg::VALUE_W'($urandom_range(0, 9));
         3:       return ddf_pkg::VALUE_W'($urandom_range(10, 99));
         4:       return ddf_pkg::VALUE_W'($urandom_range(100, 999));
         5:       return ddf_pkg::VALUE_W'($urandom_range(1000, 9999));
         default: return ddf_pkg::VALUE_W'($urandom_range(10000, 99999));
      endcase
   endfunction

   // Response side: hold ready low for random stalls while idling is on.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (idle_enable && $urandom_range(0, 3) == 0) stall_left = idle_length();
      end
   end

   // Offer one request and hold it until the block takes it. Valid stays high
   // across back-to-back requests so it is never lowered and raised in one step.
   task automatic send_request(input logic [ddf_pkg::VALUE_W-1:0] value,
                               input logic line_sel,
                               input logic [ddf_pkg::COLUMN_W-1:0] column);
      int gap;
      gap = idle_enable ? idle_length() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.value    <= value;
      req_chan.line_sel <= line_sel;
      req_chan.column   <= column;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted byte has come out.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_bytes != 0) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first stretch without idling: extremes of the number,
      // both rows and the end columns streamed back to back.
      send_request(17'd0,      1'b0, 4'd0);
      send_request(17'd131071, 1'b1, 4'd15);
      send_request(17'd99999,  1'b0, 4'd15);
      send_request(17'd100000, 1'b1, 4'd0);
      send_request(17'd1,      1'b1, 4'd5);
      send_request(17'd9,      1'b0, 4'd10);
      send_request(17'd10,     1'b1, 4'd3);
      send_request(17'd99,     1'b0, 4'd12);
      drain_responses();

      // Rest of the directed part with idling on both sides: three-, four- and
      // five-digit numbers, digit boundaries and inner zeros that must still show.
      idle_enable <= 1'b1;
      send_request(17'd100,    1'b1, 4'd1);
      send_request(17'd999,    1'b0, 4'd2);
      send_request(17'd1000,   1'b1, 4'd4);
      send_request(17'd9999,   1'b0, 4'd6);
      send_request(17'd10000,  1'b1, 4'd7);
      send_request(17'd10001,  1'b0, 4'd8);
      send_request(17'd90909,  1'b1, 4'd9);
      send_request(17'd12345,  1'b0, 4'd11);
      send_request(17'd100001, 1'b1, 4'd13);
      send_request(17'd65536,  1'b0, 4'd14);
      send_request(17'd43690,  1'b1, 4'd15);
      send_request(17'd87381,  1'b0, 4'd0);

      // Pause the sender until the block has emptied.
      drain_responses();

      // Random part: idling on, with one stretch streamed without any.
      for (int n = 0; n < 100; n++) begin
         if (n == 40) idle_enable <= 1'b0;
         if (n == 60) idle_enable <= 1'b1;
         if (n == 80) drain_responses();
         send_request(random_value(), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end

      // Wait for the last bytes, then wait on for anything stray.
      drain_responses();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hard limit, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

>>> decimal_display_formatter.f
+incdir+design
design/ddf_pkg.sv
design/ddf_req_if.sv
design/ddf_rsp_if.sv
design/ddf_digit_stage.sv
design/ddf_serializer.sv
design/decimal_display_formatter.sv
verif/display_byte_checker.sv
verif/tb.sv
